### rtl/core/ibd_pkg.sv
// Shared types and constants for the IR obstacle boxcar detector.
package ibd_pkg;

   localparam int WINDOW_DEF      = 10;
   localparam int SAMPLE_BITS_DEF = 12;
   localparam int CELL_W_DEF      = 4 * SAMPLE_BITS_DEF + 1;

   localparam int THR_W        = 12;
   localparam int GAIN_W       = 4;
   localparam int GAIN_DIVISOR = 10;
   localparam int ADDR_W       = 4;
   localparam int DATA_W       = 32;

   localparam logic [THR_W-1:0]  FRONT_THR_RESET = 12'd850;
   localparam logic [THR_W-1:0]  BACK_THR_RESET  = 12'd850;
   localparam logic              MASK_BR_RESET   = 1'b0;
   localparam logic [GAIN_W-1:0] FL_GAIN_RESET   = 4'd11;

   typedef enum logic [1:0] {
      CSR_FRONT_THR = 2'd0,
      CSR_BACK_THR  = 2'd1,
      CSR_MASK_BR   = 2'd2,
      CSR_FL_GAIN   = 2'd3
   } csr_addr_type;

   typedef struct packed {
      logic [THR_W-1:0]  front_threshold;
      logic [THR_W-1:0]  back_threshold;
      logic              mask_back_right;
      logic [GAIN_W-1:0] front_left_gain_tenths;
   } csr_cfg_type;

endpackage

### rtl/core/ibd_req_if.sv
// Request channel: four sensor samples and the suppress flag.
interface ibd_req_if import ibd_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic                   suppress;
   logic [SAMPLE_BITS-1:0] back_right_sample;
   logic [SAMPLE_BITS-1:0] back_left_sample;
   logic [SAMPLE_BITS-1:0] front_right_sample;
   logic [SAMPLE_BITS-1:0] front_left_sample;

   modport source (
      output valid, suppress, back_right_sample, back_left_sample,
             front_right_sample, front_left_sample,
      input  ready
   );
   modport sink (
      input  valid, suppress, back_right_sample, back_left_sample,
             front_right_sample, front_left_sample,
      output ready
   );
endinterface

### rtl/core/ibd_rsp_if.sv
// Response channel: front and back detection and the LED drive.
interface ibd_rsp_if;
   logic valid;
   logic ready;
   logic front_detect;
   logic back_detect;
   logic led_on;

   modport source (
      output valid, front_detect, back_detect, led_on,
      input  ready
   );
   modport sink (
      input  valid, front_detect, back_detect, led_on,
      output ready
   );
endinterface

### rtl/core/ibd_csr.sv
// APB-style configuration registers of the detector.
module ibd_csr import ibd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output csr_cfg_type       cfg
);

   csr_cfg_type  cfg_ff, cfg_in;
   csr_addr_type reg_sel;
   logic         wr_en;

   assign reg_sel = csr_addr_type'(paddr[3:2]);
   assign wr_en   = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            CSR_FRONT_THR: cfg_in.front_threshold        = pwdata[THR_W-1:0];
            CSR_BACK_THR:  cfg_in.back_threshold         = pwdata[THR_W-1:0];
            CSR_MASK_BR:   cfg_in.mask_back_right        = pwdata[0];
            CSR_FL_GAIN:   cfg_in.front_left_gain_tenths = pwdata[GAIN_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.front_threshold        <= FRONT_THR_RESET;
         cfg_ff.back_threshold         <= BACK_THR_RESET;
         cfg_ff.mask_back_right        <= MASK_BR_RESET;
         cfg_ff.front_left_gain_tenths <= FL_GAIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_sel)
         CSR_FRONT_THR: prdata = DATA_W'(cfg_ff.front_threshold);
         CSR_BACK_THR:  prdata = DATA_W'(cfg_ff.back_threshold);
         CSR_MASK_BR:   prdata = DATA_W'(cfg_ff.mask_back_right);
         CSR_FL_GAIN:   prdata = DATA_W'(cfg_ff.front_left_gain_tenths);
         default:       prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### rtl/core/ibd_scale.sv
// Front-left gain stage: sample * gain, then truncating divide by ten.
module ibd_scale import ibd_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   advance,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic [GAIN_W-1:0]      gain,
   output logic [SAMPLE_BITS:0]   scaled
);

   localparam int PROD_W  = SAMPLE_BITS + GAIN_W;
   localparam int SHIFT   = PROD_W + 4;
   localparam int RECIP_W = PROD_W + 1;
   localparam int QUOT_W  = PROD_W + RECIP_W;
   // ceil(2^SHIFT / 10); error term stays below one LSB for every product
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(GAIN_DIVISOR) - 64'd1) / 64'(GAIN_DIVISOR);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

   logic [PROD_W-1:0]    product_ff, product_in;
   logic [SAMPLE_BITS:0] scaled_ff, scaled_in;
   logic [QUOT_W-1:0]    quot_full;

   assign product_in = PROD_W'(sample) * PROD_W'(gain);
   assign quot_full  = QUOT_W'(product_ff) * QUOT_W'(RECIP);
   assign scaled_in  = quot_full[SHIFT +: SAMPLE_BITS+1];

   always_ff @(posedge clock) begin
      if (advance) begin
         product_ff <= product_in;
         scaled_ff  <= scaled_in;
      end
   end

   assign scaled = scaled_ff;

endmodule

### rtl/core/ibd_cell.sv
// One window cell: holds a sample set and passes it to the next cell.
module ibd_cell import ibd_pkg::*; #(
   parameter int WIDTH = CELL_W_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift,
   input  logic [WIDTH-1:0] d_in,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] data_ff, data_in;

   assign data_in = shift ? d_in : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign q = data_ff;

endmodule

### rtl/core/ir_obstacle_boxcar_detector_unit.sv
// IR obstacle detector: boxcar average per sensor with threshold compare.
//
// Usage:
//   req_bus carries one request per sensor set: four converter samples and a
//   suppress flag; a request is taken when valid and ready are both high.
//   rsp_bus returns one response per request, in order: front_detect,
//   back_detect and led_on. The APB-style port sets thresholds, the back
//   right mask and the front-left gain; write only while the block is idle.
// Pipeline: operand and gain product are registered at the taking edge,
//   then divide-by-ten, window update and threshold compare into the output
//   register follow in that order.
// Throughput: one request per cycle while the output is not stalled; the window
//   update is a single shift of the cell chain plus one add/subtract per running sum.
// Stall: the whole pipe advances only while the output register is empty or
//   being drained, so ready drops only while a response waits and the
//   receiver holds rsp_bus.ready low.
// Reset: windows, sums and LED clear to zero, registers go to their
//   defaults (thresholds 850, mask off, gain 1.1), pipe empties.
module ir_obstacle_boxcar_detector_unit import ibd_pkg::*; #(
   parameter int WINDOW      = WINDOW_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   ibd_req_if.sink           req_bus,
   ibd_rsp_if.source         rsp_bus,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   localparam int SB     = SAMPLE_BITS;
   localparam int FL_W   = SB + 1;
   localparam int CELL_W = 3 * SB + FL_W;
   localparam int SUM_W  = FL_W + $clog2(WINDOW);
   localparam int CMP_W  = ((FL_W > THR_W) ? FL_W : THR_W) + $clog2(WINDOW) + 1;

   csr_cfg_type cfg;

   ibd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   assign pready = 1'b1;

   // compare limits: threshold * WINDOW, stable while idle
   logic [CMP_W-1:0] front_limit_ff, front_limit_in;
   logic [CMP_W-1:0] back_limit_ff, back_limit_in;

   assign front_limit_in = CMP_W'(cfg.front_threshold) * CMP_W'(WINDOW);
   assign back_limit_in  = CMP_W'(cfg.back_threshold) * CMP_W'(WINDOW);

   always_ff @(posedge clock) begin
      front_limit_ff <= front_limit_in;
      back_limit_ff  <= back_limit_in;
   end

   // pipeline control
   logic advance;
   logic accept;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic s1_sup_ff, s2_sup_ff, s3_sup_ff;
   logic [SB-1:0] s1_br_ff, s1_bl_ff, s1_fr_ff;
   logic [SB-1:0] s2_br_ff, s2_bl_ff, s2_fr_ff;
   logic [FL_W-1:0] fl_scaled;

   assign advance     = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;
   assign accept      = req_bus.valid && advance;

   ibd_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale (
      .clock   (clock),
      .advance (advance),
      .sample  (req_bus.front_left_sample),
      .gain    (cfg.front_left_gain_tenths),
      .scaled  (fl_scaled)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_sup_ff <= req_bus.suppress;
         s1_br_ff  <= req_bus.back_right_sample;
         s1_bl_ff  <= req_bus.back_left_sample;
         s1_fr_ff  <= req_bus.front_right_sample;
         s2_sup_ff <= s1_sup_ff;
         s2_br_ff  <= s1_br_ff;
         s2_bl_ff  <= s1_bl_ff;
         s2_fr_ff  <= s1_fr_ff;
         s3_sup_ff <= s2_sup_ff;
      end
   end

   // window: chain of cells, newest at cell 0, oldest drops off the end
   logic              shift;
   logic [CELL_W-1:0] new_set;
   logic [CELL_W-1:0] tap [WINDOW];

   assign shift   = advance && s2_valid_ff && !s2_sup_ff;
   assign new_set = {s2_br_ff, s2_bl_ff, s2_fr_ff, fl_scaled};

   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      if (i == 0) begin : g_head
         ibd_cell #(.WIDTH(CELL_W)) u_cell (
            .clock (clock),
            .reset (reset),
            .shift (shift),
            .d_in  (new_set),
            .q     (tap[i])
         );
      end else begin : g_body
         ibd_cell #(.WIDTH(CELL_W)) u_cell (
            .clock (clock),
            .reset (reset),
            .shift (shift),
            .d_in  (tap[i-1]),
            .q     (tap[i])
         );
      end
   end

   logic [CELL_W-1:0] old_set;
   logic [SB-1:0]     old_br, old_bl, old_fr;
   logic [FL_W-1:0]   old_fl;

   assign old_set = tap[WINDOW-1];
   assign old_br  = old_set[FL_W+2*SB +: SB];
   assign old_bl  = old_set[FL_W+SB +: SB];
   assign old_fr  = old_set[FL_W +: SB];
   assign old_fl  = old_set[FL_W-1:0];

   logic [SUM_W-1:0] sum_br_ff, sum_bl_ff, sum_fr_ff, sum_fl_ff;
   logic [SUM_W-1:0] sum_br_in, sum_bl_in, sum_fr_in, sum_fl_in;

   assign sum_br_in = sum_br_ff - SUM_W'(old_br) + SUM_W'(s2_br_ff);
   assign sum_bl_in = sum_bl_ff - SUM_W'(old_bl) + SUM_W'(s2_bl_ff);
   assign sum_fr_in = sum_fr_ff - SUM_W'(old_fr) + SUM_W'(s2_fr_ff);
   assign sum_fl_in = sum_fl_ff - SUM_W'(old_fl) + SUM_W'(fl_scaled);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_br_ff <= '0;
         sum_bl_ff <= '0;
         sum_fr_ff <= '0;
         sum_fl_ff <= '0;
      end else if (shift) begin
         sum_br_ff <= sum_br_in;
         sum_bl_ff <= sum_bl_in;
         sum_fr_ff <= sum_fr_in;
         sum_fl_ff <= sum_fl_in;
      end
   end

   // threshold compare into the output register; led holds across suppress
   logic front_hit, back_hit;
   logic front_ff, front_in, back_ff, back_in, led_ff, led_in;

   assign front_hit = (CMP_W'(sum_fr_ff) > front_limit_ff) ||
                      (CMP_W'(sum_fl_ff) > front_limit_ff);
   assign back_hit  = (CMP_W'(sum_bl_ff) > back_limit_ff) ||
                      (!cfg.mask_back_right && (CMP_W'(sum_br_ff) > back_limit_ff));

   always_comb begin
      front_in = front_ff;
      back_in  = back_ff;
      led_in   = led_ff;
      if (advance && s3_valid_ff) begin
         front_in = !s3_sup_ff && front_hit;
         back_in  = !s3_sup_ff && back_hit;
         if (!s3_sup_ff) begin
            led_in = front_hit || back_hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         led_ff       <= 1'b0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= s3_valid_ff;
         end
         led_ff <= led_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff <= front_in;
      back_ff  <= back_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.front_detect = front_ff;
   assign rsp_bus.back_detect  = back_ff;
   assign rsp_bus.led_on       = led_ff;

`ifndef SYNTH
   a_led_follows_detect: assert property (@(posedge clock) disable iff (reset)
      (advance && s3_valid_ff && !s3_sup_ff) |=> (led_ff == (front_ff || back_ff)))
      else $error("led does not match detections of unsuppressed request");

   a_suppress_clears_detect: assert property (@(posedge clock) disable iff (reset)
      (advance && s3_valid_ff && s3_sup_ff) |=> (!front_ff && !back_ff && $stable(led_ff)))
      else $error("suppressed request reported a detection or moved the led");

   a_suppress_freezes_sums: assert property (@(posedge clock) disable iff (reset)
      (advance && s2_valid_ff && s2_sup_ff) |=>
         ($stable(sum_br_ff) && $stable(sum_bl_ff) && $stable(sum_fr_ff) &&
          $stable(sum_fl_ff)))
      else $error("window sums changed on a suppressed request");
`endif

endmodule

### test/tb_ir_obstacle_boxcar_detector_unit.sv
// Testbench for the IR obstacle boxcar detector: random sensor scenes, scoreboard check.
`timescale 1ns / 1ps

module tb_ir_obstacle_boxcar_detector_unit;
   import ibd_pkg::*;

   localparam int WIN        = WINDOW_DEF;
   localparam int SBITS      = SAMPLE_BITS_DEF;
   localparam int SMAX       = (1 << SBITS) - 1;
   localparam int STALL_MAX  = 3000;
   localparam int PHASES     = 8;
   localparam int PHASE_REQS = 210;

   typedef struct packed {
      logic             suppress;
      logic [SBITS-1:0] back_right;
      logic [SBITS-1:0] back_left;
      logic [SBITS-1:0] front_right;
      logic [SBITS-1:0] front_left;
   } sensor_set_type;

   typedef struct packed {
      logic front;
      logic back;
      logic led;
   } detect_type;

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   ibd_req_if #(.SAMPLE_BITS(SBITS)) req_bus ();
   ibd_rsp_if rsp_bus ();

   ir_obstacle_boxcar_detector_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   sensor_set_type sensor_sets_to_send[$];
   detect_type     expected_detects[$];
   int          requests_issued = 0;
   int          results_seen    = 0;
   int          failures        = 0;
   int          stall_cycles    = 0;
   logic        req_taken;
   logic        calm = 1'b0;

   // predictor copy of registers and window state
   int unsigned front_thr, back_thr, fl_gain;
   logic        mask_br;
   int unsigned br_win[WIN], bl_win[WIN], fr_win[WIN], fl_win[WIN];
   int unsigned sum_br, sum_bl, sum_fr, sum_fl;
   int unsigned win_pos;
   logic        led_held;

   function automatic detect_type predict_detection(sensor_set_type s);
      detect_type  d;
      int unsigned br, bl, fr;
      int unsigned fl_scaled, back_limit, front_limit;
      d = '0;
      if (!s.suppress) begin
         br          = 32'(s.back_right);
         bl          = 32'(s.back_left);
         fr          = 32'(s.front_right);
         fl_scaled   = (32'(s.front_left) * fl_gain) / GAIN_DIVISOR;
         back_limit  = back_thr * WIN;
         front_limit = front_thr * WIN;
         sum_br = sum_br - br_win[win_pos] + br;
         sum_bl = sum_bl - bl_win[win_pos] + bl;
         sum_fr = sum_fr - fr_win[win_pos] + fr;
         sum_fl = sum_fl - fl_win[win_pos] + fl_scaled;
         br_win[win_pos] = br;
         bl_win[win_pos] = bl;
         fr_win[win_pos] = fr;
         fl_win[win_pos] = fl_scaled;
         win_pos = (win_pos + 1 == WIN) ? 0 : win_pos + 1;
         d.back  = (sum_bl > back_limit) || (!mask_br && sum_br > back_limit);
         d.front = (sum_fr > front_limit) || (sum_fl > front_limit);
         led_held = d.front | d.back;
      end
      d.led = led_held;
      return d;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (sensor_sets_to_send.size() > 0 && (calm || $urandom_range(99) >= 24)) begin
            sensor_set_type s;
            s = sensor_sets_to_send.pop_front();
            req_bus.suppress           <= s.suppress;
            req_bus.back_right_sample  <= s.back_right;
            req_bus.back_left_sample   <= s.back_left;
            req_bus.front_right_sample <= s.front_right;
            req_bus.front_left_sample  <= s.front_left;
            req_bus.valid              <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_bus.ready <= !reset && (calm || $urandom_range(99) >= 24);
   end

   // monitor, scoreboard and watchdog
   always @(posedge clock) begin
      if (reset) begin
         req_taken    <= 1'b0;
         stall_cycles <= 0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready)
            expected_detects.push_back(predict_detection({req_bus.suppress,
               req_bus.back_right_sample, req_bus.back_left_sample,
               req_bus.front_right_sample, req_bus.front_left_sample}));
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_detects.size() == 0) begin
               $error("unexpected response: front_detect %0b back_detect %0b led_on %0b",
                      rsp_bus.front_detect, rsp_bus.back_detect, rsp_bus.led_on);
               failures++;
            end else begin
               detect_type e;
               e = expected_detects.pop_front();
               if (rsp_bus.front_detect !== e.front) begin
                  $error("front_detect: expected %0b, got %0b", e.front, rsp_bus.front_detect);
                  failures++;
               end
               if (rsp_bus.back_detect !== e.back) begin
                  $error("back_detect: expected %0b, got %0b", e.back, rsp_bus.back_detect);
                  failures++;
               end
               if (rsp_bus.led_on !== e.led) begin
                  $error("led_on: expected %0b, got %0b", e.led, rsp_bus.led_on);
                  failures++;
               end
            end
            results_seen++;
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_MAX) begin
            $display("simulation failed");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   task automatic send(logic sup, int br, int bl, int fr, int fl);
      sensor_sets_to_send.push_back({sup, br[SBITS-1:0], bl[SBITS-1:0],
                                     fr[SBITS-1:0], fl[SBITS-1:0]});
      requests_issued++;
   endtask

   task automatic wait_idle();
      wait (results_seen == requests_issued);
      repeat (8) @(posedge clock);
   endtask

   // register write; upper data bits carry junk that the block must drop
   task automatic csr_write(csr_addr_type reg_sel, int unsigned value);
      logic [DATA_W-1:0] data;
      data = $urandom;
      case (reg_sel)
         CSR_FRONT_THR: begin
            data[THR_W-1:0] = value[THR_W-1:0];
            front_thr = 32'(data[THR_W-1:0]);
         end
         CSR_BACK_THR: begin
            data[THR_W-1:0] = value[THR_W-1:0];
            back_thr = 32'(data[THR_W-1:0]);
         end
         CSR_MASK_BR: begin
            data[0] = value[0];
            mask_br = data[0];
         end
         CSR_FL_GAIN: begin
            data[GAIN_W-1:0] = value[GAIN_W-1:0];
            fl_gain = 32'(data[GAIN_W-1:0]);
         end
         default: begin
            data = $urandom;
         end
      endcase
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   function automatic int near(int center, int spread);
      int v;
      v = center - spread + $urandom_range(2 * spread);
      return (v < 0) ? 0 : (v > SMAX) ? SMAX : v;
   endfunction

   initial begin
      int base[4];
      int scene_left;
      int thr;
      reset   = 1'b1;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      req_bus.valid              = 1'b0;
      req_bus.suppress           = 1'b0;
      req_bus.back_right_sample  = '0;
      req_bus.back_left_sample   = '0;
      req_bus.front_right_sample = '0;
      req_bus.front_left_sample  = '0;
      rsp_bus.ready              = 1'b0;
      front_thr = 32'(FRONT_THR_RESET);
      back_thr  = 32'(BACK_THR_RESET);
      mask_br   = MASK_BR_RESET;
      fl_gain   = 32'(FL_GAIN_RESET);
      foreach (br_win[i]) begin
         br_win[i] = 0;
         bl_win[i] = 0;
         fr_win[i] = 0;
         fl_win[i] = 0;
      end
      sum_br = 0; sum_bl = 0; sum_fr = 0; sum_fl = 0;
      win_pos  = 0;
      led_held = 1'b0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: start-up zeros, saturation, suppression holding the LED
      send(1'b0, 0, 0, 0, 0);
      send(1'b1, SMAX, SMAX, SMAX, SMAX);
      repeat (10) send(1'b0, SMAX, SMAX, SMAX, SMAX);
      send(1'b1, 0, 0, 0, 0);
      send(1'b1, 'hAAA, 'h555, 'hAAA, 'h555);
      repeat (9) send(1'b0, 0, 0, 0, 0);
      repeat (3) send(1'b0, 0, 0, 0, SMAX);
      wait_idle();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               csr_write(CSR_FRONT_THR, 0);
               csr_write(CSR_BACK_THR, 0);
               csr_write(CSR_MASK_BR, 1);
               csr_write(CSR_FL_GAIN, 0);
            end
            1: begin
               csr_write(CSR_FRONT_THR, SMAX);
               csr_write(CSR_BACK_THR, SMAX);
               csr_write(CSR_MASK_BR, 0);
               csr_write(CSR_FL_GAIN, 15);
            end
            2: begin
               csr_write(CSR_FRONT_THR, 32'(FRONT_THR_RESET));
               csr_write(CSR_BACK_THR, 32'(BACK_THR_RESET));
               csr_write(CSR_MASK_BR, 1);
               csr_write(CSR_FL_GAIN, 10);
            end
            default: begin
               csr_write(CSR_FRONT_THR, $urandom_range(SMAX));
               csr_write(CSR_BACK_THR, $urandom_range(SMAX));
               csr_write(CSR_MASK_BR, $urandom_range(1));
               csr_write(CSR_FL_GAIN, $urandom_range(15));
            end
         endcase
         calm = (p == 4);
         scene_left = 0;
         for (int n = 0; n < PHASE_REQS; n++) begin
            // a scene holds each sensor near a level, mostly close to its threshold
            if (scene_left == 0) begin
               scene_left = $urandom_range(4, 30);
               for (int c = 0; c < 4; c++) begin
                  thr = (c < 2) ? back_thr : (c == 2) ? front_thr
                      : (fl_gain == 0) ? $urandom_range(SMAX) : front_thr * 10 / fl_gain;
                  base[c] = ($urandom_range(99) < 70) ? near(thr, 400) : $urandom_range(SMAX);
               end
            end
            scene_left--;
            send($urandom_range(99) < 8,
                 ($urandom_range(99) < 3) ? $urandom_range(SMAX) : near(base[0], 64),
                 ($urandom_range(99) < 3) ? $urandom_range(SMAX) : near(base[1], 64),
                 ($urandom_range(99) < 3) ? $urandom_range(SMAX) : near(base[2], 64),
                 ($urandom_range(99) < 3) ? $urandom_range(SMAX) : near(base[3], 64));
         end
         wait_idle();
      end
      calm = 1'b0;

      wait (results_seen == requests_issued);
      repeat (20) @(posedge clock);
      if (failures == 0 && expected_detects.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
